// File: design/rdeu_pkg.sv
// ----------------------------------------------------------------------------
// rdeu_pkg
// Shared types, constants and helpers of the radix digit emitter.
// ----------------------------------------------------------------------------
package rdeu_pkg;

   localparam int VALUE_WIDTH_DEF = 64;
   localparam int MAX_DIGITS_DEF  = 64;

   localparam int RADIX_W  = 5;
   localparam int DIGIT_W  = 4;
   localparam int DIV_BITS = 4;   // quotient bits retired per divide cycle

   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_STORE,
      ST_FETCH,
      ST_SHOW
   } state_type;

   typedef struct packed {
      logic load;       // capture a new value, clear count and remainder
      logic div_step;   // retire DIV_BITS quotient bits
      logic store;      // write remainder digit, start next digit
      logic fetch;      // read one digit into the output register
      logic advance;    // step read pointer toward the last digit
   } cmd_type;

   typedef struct packed {
      logic q_zero;     // running quotient is zero
      logic count_last; // the digit being stored fills the store
      logic ptr_zero;   // output register holds the final digit
   } status_type;

   // Clamp the written radix into the legal range.
   function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] res;
      res = r;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end
      return res;
   endfunction

endpackage

// File: design/integer_radix_digit_emitter_unit.sv
// ----------------------------------------------------------------------------
// integer_radix_digit_emitter_unit
// Converts a signed integer to radix 2..16 digits, most significant first.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  ------------------------------------------
//  req      in   tvalid / tready    tdata : value (signed, VALUE_WIDTH bits)
//  rsp      out  tvalid / tready    tdata : digit; tuser : negative; tlast
//  csr      in   valid / ready      data  : radix (5 bits, reset 10)
//
//  Each digit comes from a full pass of the shared 4-bit-per-cycle
//  restoring divider; the stored digits are then played back.
//  Reset clears the sequencer, counters and radix (back to 10); the digit
//  store is not cleared, every entry read is written first in the same item.
//  One item is in flight at a time; req_tready is high only when idle.
//  A stalled rsp beat holds its digit, sign and last flag until taken.
//
module integer_radix_digit_emitter_unit #(
   parameter int VALUE_WIDTH = rdeu_pkg::VALUE_WIDTH_DEF,
   parameter int MAX_DIGITS  = rdeu_pkg::MAX_DIGITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration write
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rdeu_pkg::RADIX_W-1:0]          csr_data,
   // input stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] req_tdata,  // [VALUE_WIDTH-1:0] value
   // result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [7:0]                            rsp_tdata,   // [3:0] digit
   output logic                                  rsp_tuser,   // [0] negative
   output logic                                  rsp_tlast
);

   rdeu_pkg::cmd_type                cmd;
   rdeu_pkg::status_type             status;
   logic [rdeu_pkg::DIGIT_W-1:0]     digit;
   logic                             negative;

   // Radix register always takes the write; software writes it only when idle.
   assign csr_ready = 1'b1;

   rdeu_ctrl #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   rdeu_dpath #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .MAX_DIGITS  (MAX_DIGITS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_valid & csr_ready),
      .csr_data (csr_data),
      .value    (req_tdata[VALUE_WIDTH-1:0]),
      .cmd      (cmd),
      .status   (status),
      .digit    (digit),
      .negative (negative)
   );

   // Pad the digit up to a whole byte.
   assign rsp_tdata = 8'(digit);
   assign rsp_tuser = negative;
   assign rsp_tlast = status.ptr_zero;

endmodule

// File: design/rdeu_ctrl.sv
// ----------------------------------------------------------------------------
// rdeu_ctrl
// Sequencer: divide loop per digit, then digit playback most significant first.
// ----------------------------------------------------------------------------
module rdeu_ctrl #(
   parameter int VALUE_WIDTH = rdeu_pkg::VALUE_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  rdeu_pkg::status_type status,
   output rdeu_pkg::cmd_type    cmd
);

   localparam int STEPS = (VALUE_WIDTH + rdeu_pkg::DIV_BITS - 1) / rdeu_pkg::DIV_BITS;
   localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam logic [SW-1:0] STEP_LAST = SW'(STEPS - 1);

   rdeu_pkg::state_type state_ff, state_in;
   logic [SW-1:0]       step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rdeu_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         rdeu_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = rdeu_pkg::ST_DIVIDE;
            end
         end
         rdeu_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = rdeu_pkg::ST_STORE;
            end
         end
         rdeu_pkg::ST_STORE: begin
            cmd.store = 1'b1;
            step_in   = '0;
            if (status.q_zero || status.count_last) begin
               state_in = rdeu_pkg::ST_FETCH;
            end else begin
               state_in = rdeu_pkg::ST_DIVIDE;
            end
         end
         rdeu_pkg::ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = rdeu_pkg::ST_SHOW;
         end
         rdeu_pkg::ST_SHOW: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.ptr_zero) begin
                  state_in = rdeu_pkg::ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = rdeu_pkg::ST_FETCH;
               end
            end
         end
         default: begin
            state_in = rdeu_pkg::ST_IDLE;
         end
      endcase
   end

   // A new beat always starts the divide loop.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == rdeu_pkg::ST_DIVIDE && step_ff == '0))
      else $error("divide loop not started after accepted beat");

   // A digit is stored only after a full pass of divide steps.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == rdeu_pkg::ST_STORE) |->
         ($past(state_ff) == rdeu_pkg::ST_DIVIDE && $past(step_ff) == STEP_LAST))
      else $error("digit stored before division finished");

endmodule

// File: design/rdeu_dpath.sv
// ----------------------------------------------------------------------------
// rdeu_dpath
// Quotient/remainder divider, digit store and output register.
// ----------------------------------------------------------------------------
module rdeu_dpath #(
   parameter int VALUE_WIDTH = rdeu_pkg::VALUE_WIDTH_DEF,
   parameter int MAX_DIGITS  = rdeu_pkg::MAX_DIGITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [rdeu_pkg::RADIX_W-1:0]     csr_data,
   input  logic [VALUE_WIDTH-1:0]           value,
   input  rdeu_pkg::cmd_type                cmd,
   output rdeu_pkg::status_type             status,
   output logic [rdeu_pkg::DIGIT_W-1:0]     digit,
   output logic                             negative
);

   localparam int DB = rdeu_pkg::DIV_BITS;
   localparam int QW = ((VALUE_WIDTH + DB - 1) / DB) * DB;
   localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CW = $clog2(MAX_DIGITS + 1);
   localparam int RW = rdeu_pkg::RADIX_W;
   localparam int DW = rdeu_pkg::DIGIT_W;

   logic [RW-1:0]      radix_ff, radix_in;
   logic [RW-1:0]      radix_eff;
   logic [QW-1:0]      quot_ff, quot_in;
   logic [DW-1:0]      rem_ff, rem_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      ptr_ff, ptr_in;
   logic               sign_ff, sign_in;
   logic [DW-1:0]      digit_ff;
   logic [DW-1:0]      store_mem [MAX_DIGITS];

   logic [VALUE_WIDTH-1:0] mag;
   logic [QW-1:0]          q_step;
   logic [DW-1:0]          r_step;
   logic [DW:0]            trial;

   assign radix_eff = rdeu_pkg::eff_radix(radix_ff);
   assign mag       = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

   // Restoring division, DB bits per cycle on a narrow remainder.
   always_comb begin
      q_step = quot_ff;
      r_step = rem_ff;
      trial  = '0;
      for (int i = 0; i < DB; i++) begin
         trial  = {r_step, q_step[QW-1]};
         q_step = {q_step[QW-2:0], 1'b0};
         if (trial >= radix_eff) begin
            trial     = trial - (DW + 1)'(radix_eff);
            q_step[0] = 1'b1;
         end
         r_step = trial[DW-1:0];
      end
   end

   always_comb begin
      radix_in = csr_we ? csr_data : radix_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      sign_in  = sign_ff;
      if (cmd.load) begin
         quot_in  = QW'(mag);
         rem_in   = '0;
         count_in = '0;
         sign_in  = value[VALUE_WIDTH-1];
      end
      if (cmd.div_step) begin
         quot_in = q_step;
         rem_in  = r_step;
      end
      if (cmd.store) begin
         rem_in   = '0;
         count_in = count_ff + 1'b1;
         ptr_in   = count_ff[IW-1:0];
      end
      if (cmd.advance) begin
         ptr_in = ptr_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= rdeu_pkg::RADIX_RESET;
         quot_ff  <= '0;
         rem_ff   <= '0;
         count_ff <= '0;
         ptr_ff   <= '0;
         sign_ff  <= 1'b0;
      end else begin
         radix_ff <= radix_in;
         quot_ff  <= quot_in;
         rem_ff   <= rem_in;
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
         sign_ff  <= sign_in;
      end
   end

   // Digit store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         store_mem[count_ff[IW-1:0]] <= rem_ff;
      end
      if (cmd.fetch) begin
         digit_ff <= store_mem[ptr_ff];
      end
   end

   assign status.q_zero     = (quot_ff == '0);
   assign status.count_last = (count_ff == CW'(MAX_DIGITS - 1));
   assign status.ptr_zero   = (ptr_ff == '0);
   assign digit             = digit_ff;
   assign negative          = sign_ff;

   // The remainder stays a valid digit of the radix throughout division.
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (RW'(rem_ff) < radix_eff))
      else $error("remainder out of range during division");

   // Never write past the end of the digit store.
   assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> (count_ff < CW'(MAX_DIGITS)))
      else $error("digit store overflow");

endmodule
